[rtl/core/rgtd_pkg.sv]
package rgtd_pkg;

    // fixed field widths
    localparam int TICK_W    = 48;
    localparam int ELAPSED_W = 32;
    localparam int MASK_W    = 3;
    localparam int UNIT_W    = TICK_W + 2;
    localparam int CNT_W     = $clog2(TICK_W + 1);

    // wrap limit ceiling
    localparam logic [TICK_W-1:0] LIMIT_MAX = '1;

    // configuration register map
    localparam int CFG_IDX_W       = 3;
    localparam int REG_DIV_BASE    = 0;
    localparam int REG_OFF_BASE    = 1;
    localparam int REG_SLOT_STRIDE = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd7;

    // shared adder operation
    typedef enum logic {
        UOP_ADD = 1'b0,
        UOP_SUB = 1'b1
    } unit_op_t;

    typedef struct packed {
        unit_op_t          op;
        logic [UNIT_W-1:0] a;
        logic [UNIT_W-1:0] b;
    } unit_req_t;

    typedef struct packed {
        logic [UNIT_W-1:0] sum;
        logic              carry;
    } unit_rsp_t;

    // one result beat
    typedef struct packed {
        logic [MASK_W-1:0]    fire_mask;
        logic [ELAPSED_W-1:0] cycle_time;
        logic [ELAPSED_W-1:0] max_cycle_time;
    } rgtd_result_t;

endpackage

[rtl/core/rgtd_tick_if.sv]
interface rgtd_tick_if
    import rgtd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ELAPSED_W-1:0] elapsed_us;

    modport source (output valid, output elapsed_us, input ready);
    modport sink (input valid, input elapsed_us, output ready);
endinterface

[rtl/core/rgtd_status_if.sv]
interface rgtd_status_if
    import rgtd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [MASK_W-1:0]    fire_mask;
    logic [ELAPSED_W-1:0] cycle_time;
    logic [ELAPSED_W-1:0] max_cycle_time;

    modport source (output valid, output fire_mask, output cycle_time, output max_cycle_time,
                    input ready);
    modport sink (input valid, input fire_mask, input cycle_time, input max_cycle_time,
                  output ready);
endinterface

[rtl/core/rgtd_cfg_regs.sv]
module rgtd_cfg_regs
    import rgtd_pkg::*;
#(
    parameter int NUM_SLOTS    = 3,
    parameter int DIVISOR_BITS = 16
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                     cfg_index,
    input  logic [DIVISOR_BITS-1:0]                  cfg_data,
    input  logic                                     limit_done,
    output logic [NUM_SLOTS-1:0][DIVISOR_BITS-1:0]   divisor,
    output logic [NUM_SLOTS-1:0][DIVISOR_BITS-1:0]   offset,
    output logic [MASK_W-1:0]                        conn_mask,
    output logic                                     limit_dirty
);

    logic [NUM_SLOTS-1:0][DIVISOR_BITS-1:0] divisor_reg;
    logic [NUM_SLOTS-1:0][DIVISOR_BITS-1:0] offset_reg;
    logic [MASK_W-1:0]                      mask_reg;
    logic                                   dirty_reg;

    // register file, decoded per slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= '0;
            offset_reg  <= '0;
            mask_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                if (cfg_index == CFG_IDX_W'(REG_DIV_BASE + REG_SLOT_STRIDE * s))
                begin
                    divisor_reg[s] <= cfg_data;
                end
                if (cfg_index == CFG_IDX_W'(REG_OFF_BASE + REG_SLOT_STRIDE * s))
                begin
                    offset_reg[s] <= cfg_data;
                end
            end
            if (cfg_index == REG_MASK)
            begin
                mask_reg <= cfg_data[MASK_W-1:0];
            end
        end
    end

    // wrap limit must be rebuilt after any valid write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg <= 1'b0;
        end
        else if (cfg_wr_en && (cfg_index < REG_COUNT))
        begin
            dirty_reg <= 1'b1;
        end
        else if (limit_done)
        begin
            dirty_reg <= 1'b0;
        end
    end

    assign divisor     = divisor_reg;
    assign offset      = offset_reg;
    assign conn_mask   = mask_reg;
    assign limit_dirty = dirty_reg;

endmodule

[rtl/core/rgtd_arith_unit.sv]
module rgtd_arith_unit
    import rgtd_pkg::*;
(
    input  unit_req_t req,
    output unit_rsp_t rsp
);

    logic [UNIT_W-1:0] b_op;
    logic [UNIT_W:0]   total;

    // add, or subtract with carry out meaning a >= b
    assign b_op  = (req.op == UOP_SUB) ? ~req.b : req.b;
    assign total = {1'b0, req.a} + {1'b0, b_op} + (UNIT_W + 1)'(req.op == UOP_SUB);

    assign rsp.sum   = total[UNIT_W-1:0];
    assign rsp.carry = total[UNIT_W];

endmodule

[rtl/core/rgtd_seq.sv]
module rgtd_seq
    import rgtd_pkg::*;
#(
    parameter int NUM_SLOTS    = 3,
    parameter int DIVISOR_BITS = 16
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic [ELAPSED_W-1:0]                     start_elapsed,
    output logic                                     idle,
    input  logic [NUM_SLOTS-1:0][DIVISOR_BITS-1:0]   divisor,
    input  logic [NUM_SLOTS-1:0][DIVISOR_BITS-1:0]   offset,
    input  logic [MASK_W-1:0]                        conn_mask,
    input  logic                                     limit_dirty,
    output logic                                     limit_done,
    output logic                                     res_valid,
    input  logic                                     res_ready,
    output rgtd_result_t                             res,
    output unit_req_t                                unit_req,
    input  unit_rsp_t                                unit_rsp
);

    localparam int DB        = DIVISOR_BITS;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int DIV_IDX_W = $clog2(DIVISOR_BITS);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_PROD = 8'b0000_0010,
        S_MOD  = 8'b0000_0100,
        S_INC  = 8'b0000_1000,
        S_CMP  = 8'b0001_0000,
        S_WRAP = 8'b0010_0000,
        S_MAX  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } seq_state_t;

    seq_state_t           state_reg, state_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [UNIT_W-1:0]    acc_reg, acc_next;
    logic                 sat_reg, sat_next;
    logic [TICK_W-1:0]    rem_reg, rem_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [TICK_W-1:0]    wrap_reg, wrap_next;
    logic [ELAPSED_W-1:0] longest_reg, longest_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [MASK_W-1:0]    fire_reg, fire_next;

    logic [DB-1:0]        cur_div;
    logic [DB-1:0]        cur_off;
    logic                 eligible;
    logic                 last_slot;
    logic                 prod_bit;
    logic                 prod_ovf;
    logic [DB:0]          mod_sh;
    logic [DB-1:0]        mod_rem;
    logic [TICK_W:0]      wrap_sh;
    logic [TICK_W-1:0]    wrap_rem;

    // current slot view
    assign cur_div   = divisor[slot_reg];
    assign cur_off   = offset[slot_reg];
    assign eligible  = (cur_div != '0) && conn_mask[slot_reg];
    assign last_slot = (slot_reg == SLOT_W'(NUM_SLOTS - 1));
    assign prod_bit  = cur_div[cnt_reg[DIV_IDX_W-1:0]];
    assign prod_ovf  = |unit_rsp.sum[UNIT_W-1:TICK_W];

    // restoring remainder steps, one dividend bit per cycle
    assign mod_sh   = {rem_reg[DB-1:0], tick_reg[cnt_reg]};
    assign mod_rem  = unit_rsp.carry ? unit_rsp.sum[DB-1:0] : mod_sh[DB-1:0];
    assign wrap_sh  = {rem_reg, acc_reg[cnt_reg]};
    assign wrap_rem = unit_rsp.carry ? unit_rsp.sum[TICK_W-1:0] : wrap_sh[TICK_W-1:0];

    // operands for the shared adder
    always_comb
    begin
        unit_req.op = UOP_ADD;
        unit_req.a  = '0;
        unit_req.b  = '0;
        unique case (state_reg)
            S_PROD:
            begin
                unit_req.op = UOP_ADD;
                unit_req.a  = {acc_reg[UNIT_W-2:0], 1'b0};
                unit_req.b  = prod_bit ? UNIT_W'(wrap_reg) : '0;
            end
            S_MOD:
            begin
                unit_req.op = UOP_SUB;
                unit_req.a  = UNIT_W'(mod_sh);
                unit_req.b  = UNIT_W'(cur_div);
            end
            S_INC:
            begin
                unit_req.op = UOP_ADD;
                unit_req.a  = UNIT_W'(tick_reg);
                unit_req.b  = UNIT_W'(1);
            end
            S_CMP:
            begin
                unit_req.op = UOP_SUB;
                unit_req.a  = acc_reg;
                unit_req.b  = UNIT_W'(wrap_reg);
            end
            S_WRAP:
            begin
                unit_req.op = UOP_SUB;
                unit_req.a  = UNIT_W'(wrap_sh);
                unit_req.b  = UNIT_W'(wrap_reg);
            end
            S_MAX:
            begin
                unit_req.op = UOP_SUB;
                unit_req.a  = UNIT_W'(elapsed_reg);
                unit_req.b  = UNIT_W'(longest_reg);
            end
            S_IDLE, S_OUT:
            begin
                unit_req.op = UOP_ADD;
            end
            default:
            begin
                unit_req.op = UOP_ADD;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        sat_next     = sat_reg;
        rem_next     = rem_reg;
        tick_next    = tick_reg;
        wrap_next    = wrap_reg;
        longest_next = longest_reg;
        elapsed_next = elapsed_reg;
        fire_next    = fire_reg;
        limit_done   = 1'b0;
        res_valid    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    elapsed_next = start_elapsed;
                    fire_next    = '0;
                    slot_next    = '0;
                    acc_next     = '0;
                    sat_next     = 1'b0;
                    rem_next     = '0;
                    if (limit_dirty)
                    begin
                        wrap_next  = TICK_W'(1);
                        cnt_next   = CNT_W'(DB - 1);
                        state_next = S_PROD;
                    end
                    else
                    begin
                        cnt_next   = CNT_W'(TICK_W - 1);
                        state_next = S_MOD;
                    end
                end
            end

            // wrap limit: msb-first shift-add per nonzero divisor, saturating
            S_PROD:
            begin
                if ((cur_div == '0) || (cnt_reg == '0))
                begin
                    if (cur_div != '0)
                    begin
                        wrap_next = (sat_reg || prod_ovf) ? LIMIT_MAX
                                                          : unit_rsp.sum[TICK_W-1:0];
                    end
                    acc_next = '0;
                    sat_next = 1'b0;
                    cnt_next = CNT_W'(DB - 1);
                    if (last_slot)
                    begin
                        limit_done = 1'b1;
                        slot_next  = '0;
                        rem_next   = '0;
                        cnt_next   = CNT_W'(TICK_W - 1);
                        state_next = S_MOD;
                    end
                    else
                    begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
                else
                begin
                    acc_next = unit_rsp.sum;
                    sat_next = sat_reg || prod_ovf;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end

            // tick count modulo the slot divisor
            S_MOD:
            begin
                if (eligible && (cnt_reg != '0))
                begin
                    rem_next = TICK_W'(mod_rem);
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    if (eligible)
                    begin
                        fire_next[slot_reg] = (mod_rem == cur_off);
                    end
                    rem_next = '0;
                    cnt_next = CNT_W'(TICK_W - 1);
                    if (last_slot)
                    begin
                        slot_next  = '0;
                        state_next = S_INC;
                    end
                    else
                    begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
            end

            S_INC:
            begin
                acc_next   = unit_rsp.sum;
                state_next = S_CMP;
            end

            // in range, exactly at the limit, or far past it after a reconfig
            S_CMP:
            begin
                if (!unit_rsp.carry)
                begin
                    tick_next  = acc_reg[TICK_W-1:0];
                    state_next = S_MAX;
                end
                else if (unit_rsp.sum == '0)
                begin
                    tick_next  = '0;
                    state_next = S_MAX;
                end
                else
                begin
                    rem_next   = '0;
                    cnt_next   = CNT_W'(TICK_W);
                    state_next = S_WRAP;
                end
            end

            S_WRAP:
            begin
                rem_next = wrap_rem;
                if (cnt_reg == '0)
                begin
                    tick_next  = wrap_rem;
                    state_next = S_MAX;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end

            S_MAX:
            begin
                if (unit_rsp.carry)
                begin
                    longest_next = elapsed_reg;
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            slot_reg    <= '0;
            cnt_reg     <= '0;
            sat_reg     <= 1'b0;
            tick_reg    <= '0;
            wrap_reg    <= TICK_W'(1);
            longest_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            cnt_reg     <= cnt_next;
            sat_reg     <= sat_next;
            tick_reg    <= tick_next;
            wrap_reg    <= wrap_next;
            longest_reg <= longest_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        elapsed_reg <= elapsed_next;
        fire_reg    <= fire_next;
    end

    assign idle               = (state_reg == S_IDLE);
    assign res.fire_mask      = fire_reg;
    assign res.cycle_time     = elapsed_reg;
    assign res.max_cycle_time = longest_reg;

endmodule

[rtl/core/rate_group_tick_divider_core.sv]
// steps: limit rebuild if dirty, slot remainders, increment, compare, wrap, max update, output
// the shared 50-bit adder does one remainder bit per cycle, over each enabled, connected slot
// after a config write the next tick rebuilds the wrap limit from the nonzero divisors
// a tick whose count lands past a newly lowered wrap limit adds a reduction modulo the limit
// one tick at a time: the next is taken when the sequencer idles after its result is registered
// reset: async active low; config, tick count, max time cleared, wrap limit set to one
module rate_group_tick_divider_core
    import rgtd_pkg::*;
#(
    parameter int NUM_SLOTS    = 3,
    parameter int DIVISOR_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    rgtd_tick_if.sink               tick,
    rgtd_status_if.source           status,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [DIVISOR_BITS-1:0] cfg_data
);

    logic [NUM_SLOTS-1:0][DIVISOR_BITS-1:0] divisor;
    logic [NUM_SLOTS-1:0][DIVISOR_BITS-1:0] offset;
    logic [MASK_W-1:0]                      conn_mask;
    logic                                   limit_dirty;
    logic                                   limit_done;
    logic                                   seq_idle;
    logic                                   res_valid;
    logic                                   res_ready;
    rgtd_result_t                           res;
    unit_req_t                              unit_req;
    unit_rsp_t                              unit_rsp;

    logic                                   out_valid_reg;
    rgtd_result_t                           out_data_reg;

    rgtd_cfg_regs #(
        .NUM_SLOTS    (NUM_SLOTS),
        .DIVISOR_BITS (DIVISOR_BITS)
    ) u_cfg_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .limit_done  (limit_done),
        .divisor     (divisor),
        .offset      (offset),
        .conn_mask   (conn_mask),
        .limit_dirty (limit_dirty)
    );

    rgtd_arith_unit u_arith_unit (
        .req (unit_req),
        .rsp (unit_rsp)
    );

    rgtd_seq #(
        .NUM_SLOTS    (NUM_SLOTS),
        .DIVISOR_BITS (DIVISOR_BITS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (tick.valid && tick.ready),
        .start_elapsed (tick.elapsed_us),
        .idle          (seq_idle),
        .divisor       (divisor),
        .offset        (offset),
        .conn_mask     (conn_mask),
        .limit_dirty   (limit_dirty),
        .limit_done    (limit_done),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .unit_req      (unit_req),
        .unit_rsp      (unit_rsp)
    );

    // input side takes a tick whenever the sequencer is free
    assign tick.ready = seq_idle;

    // output register, refilled in the same cycle it drains
    assign res_ready = !out_valid_reg || status.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (status.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign status.valid          = out_valid_reg;
    assign status.fire_mask      = out_data_reg.fire_mask;
    assign status.cycle_time     = out_data_reg.cycle_time;
    assign status.max_cycle_time = out_data_reg.max_cycle_time;

endmodule

[rtl/core/rgtd_checker.sv]
module rgtd_checker
    import rgtd_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [MASK_W-1:0]    out_fire,
    input logic [ELAPSED_W-1:0] out_cycle,
    input logic [ELAPSED_W-1:0] out_max
);

    logic                 seen_reg;
    logic [ELAPSED_W-1:0] last_max_reg;

    // max time of the last delivered beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            last_max_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            seen_reg     <= 1'b1;
            last_max_reg <= out_max;
        end
    end

    // running max covers this beat's own time
    a_max_covers_cycle: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_max >= out_cycle)
    ) else $error("max cycle time below cycle time");

    // running max never goes down between beats
    a_max_monotonic: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && seen_reg) |-> (out_max >= last_max_reg)
    ) else $error("max cycle time decreased");

    // one tick at a time: busy right after a tick is taken
    a_busy_after_tick: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("tick accepted while previous tick in progress");

    // stalled result beat holds
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_fire) && $stable(out_cycle) && $stable(out_max))
    ) else $error("result beat changed while stalled");

endmodule

bind rate_group_tick_divider_core rgtd_checker u_rgtd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tick.valid),
    .in_ready  (tick.ready),
    .out_valid (status.valid),
    .out_ready (status.ready),
    .out_fire  (status.fire_mask),
    .out_cycle (status.cycle_time),
    .out_max   (status.max_cycle_time)
);

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench
    import rgtd_pkg::*;
();

    localparam int NUM_SLOTS     = 3;
    localparam int DIVISOR_BITS  = 16;
    localparam int IDLE_PCT      = 29;
    localparam int RANDOM_PHASES = 45;
    localparam int HOLD_CYCLES   = 600;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 300;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [DIVISOR_BITS-1:0] cfg_data;

    rgtd_tick_if   tick ();
    rgtd_status_if status ();

    rate_group_tick_divider_core #(
        .NUM_SLOTS    (NUM_SLOTS),
        .DIVISOR_BITS (DIVISOR_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .status    (status),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // divider state as the block should hold it
    logic [DIVISOR_BITS-1:0] slot_div [MASK_W];
    logic [DIVISOR_BITS-1:0] slot_off [MASK_W];
    logic [MASK_W-1:0]       slot_conn;
    logic [TICK_W-1:0]       tick_count;
    logic [TICK_W-1:0]       wrap_limit;
    logic [ELAPSED_W-1:0]    longest_cycle;

    // settings to load in the next configuration pass
    logic [DIVISOR_BITS-1:0] next_div [MASK_W];
    logic [DIVISOR_BITS-1:0] next_off [MASK_W];
    logic [DIVISOR_BITS-1:0] next_conn;

    rgtd_result_t status_expected [$];
    int           errors       = 0;
    int           quiet_cycles = 0;
    int           hold_left    = 0;
    bit           send_idle    = 1'b1;
    bit           recv_idle    = 1'b1;

    // wrap limit is the product of the nonzero divisors, saturating at 48 bits
    function automatic void update_wrap_limit();
        logic [2*TICK_W-1:0] prod;
        int                  s;
        prod = 1;
        for (s = 0; s < NUM_SLOTS && s < MASK_W; s++)
        begin
            if (slot_div[s] != 0)
            begin
                prod = prod * slot_div[s];
                if (prod > LIMIT_MAX)
                    prod = LIMIT_MAX;
            end
        end
        wrap_limit = prod[TICK_W-1:0];
    endfunction

    function automatic void divider_reset();
        int s;
        for (s = 0; s < MASK_W; s++)
        begin
            slot_div[s] = '0;
            slot_off[s] = '0;
        end
        slot_conn     = '0;
        tick_count    = '0;
        wrap_limit    = 1;
        longest_cycle = '0;
    endfunction

    // register write; unknown index is dropped, mask keeps its low bits only
    function automatic void divider_write(logic [CFG_IDX_W-1:0] idx,
                                          logic [DIVISOR_BITS-1:0] data);
        if (idx == REG_COUNT)
            return;
        if (idx == REG_MASK)
            slot_conn = data[MASK_W-1:0];
        else if ((idx - REG_DIV_BASE) % REG_SLOT_STRIDE == REG_OFF_BASE - REG_DIV_BASE)
            slot_off[(idx - REG_DIV_BASE) / REG_SLOT_STRIDE] = data;
        else
            slot_div[(idx - REG_DIV_BASE) / REG_SLOT_STRIDE] = data;
        update_wrap_limit();
    endfunction

    // fire mask from the count before the advance, max time after the update
    function automatic rgtd_result_t predict_status(logic [ELAPSED_W-1:0] elapsed);
        rgtd_result_t r;
        int           s;
        r.fire_mask = '0;
        for (s = 0; s < NUM_SLOTS && s < MASK_W; s++)
        begin
            if (slot_div[s] != 0 && slot_conn[s] && (tick_count % slot_div[s]) == slot_off[s])
                r.fire_mask[s] = 1'b1;
        end
        tick_count = (tick_count + 1) % wrap_limit;
        if (elapsed > longest_cycle)
            longest_cycle = elapsed;
        r.cycle_time     = elapsed;
        r.max_cycle_time = longest_cycle;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic check_status();
        rgtd_result_t want;
        if (status_expected.size() == 0)
        begin
            report_mismatch("status beat with nothing pending", status.cycle_time, 0);
            return;
        end
        want = status_expected.pop_front();
        if (status.fire_mask !== want.fire_mask)
            report_mismatch("fire_mask", status.fire_mask, want.fire_mask);
        if (status.cycle_time !== want.cycle_time)
            report_mismatch("cycle_time", status.cycle_time, want.cycle_time);
        if (status.max_cycle_time !== want.max_cycle_time)
            report_mismatch("max_cycle_time", status.max_cycle_time, want.max_cycle_time);
    endtask

    // one tick beat, with random gaps ahead of it when the sender idles
    task automatic send_tick(input logic [ELAPSED_W-1:0] elapsed);
        if (send_idle)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                tick.valid      <= 1'b0;
                tick.elapsed_us <= $urandom;
                @(posedge clk);
            end
        end
        tick.valid      <= 1'b1;
        tick.elapsed_us <= elapsed;
        do
            @(posedge clk);
        while (!tick.ready);
        status_expected.push_back(predict_status(elapsed));
    endtask

    // stop offering ticks and wait for every pending status beat
    task automatic wait_drained();
        if (tick.valid)
            tick.valid <= 1'b0;
        while (status_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DIVISOR_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        divider_write(idx, data);
    endtask

    // load every register while the block is idle, plus a write to the unused index
    task automatic apply_settings();
        int s;
        wait_drained();
        for (s = 0; s < MASK_W; s++)
        begin
            write_reg(CFG_IDX_W'(REG_DIV_BASE + s * REG_SLOT_STRIDE), next_div[s]);
            write_reg(CFG_IDX_W'(REG_OFF_BASE + s * REG_SLOT_STRIDE), next_off[s]);
        end
        write_reg(REG_MASK, next_conn);
        write_reg(REG_COUNT, DIVISOR_BITS'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void set_slot(int s, logic [DIVISOR_BITS-1:0] div,
                                     logic [DIVISOR_BITS-1:0] off);
        next_div[s] = div;
        next_off[s] = off;
    endfunction

    // mostly small divisors with an offset in range so slots really fire
    function automatic void pick_settings();
        int s;
        int kind;
        for (s = 0; s < MASK_W; s++)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                next_div[s] = '0;
            else if (kind == 1)
                next_div[s] = $urandom_range(13, 65535);
            else
                next_div[s] = $urandom_range(1, 12);
            if (next_div[s] != 0 && $urandom_range(0, 4) != 0)
                next_off[s] = $urandom_range(0, next_div[s] - 1);
            else if ($urandom_range(0, 1) != 0)
                next_off[s] = next_div[s] + $urandom_range(0, 2);
            else
                next_off[s] = $urandom_range(0, 65535);
        end
        next_conn = $urandom_range(0, 1) ? ($urandom | 7) : $urandom;
    endfunction

    // durations of random magnitude, shifted right by at least floor bits
    function automatic logic [ELAPSED_W-1:0] draw_elapsed(int floor);
        return $urandom >> $urandom_range(floor, 31);
    endfunction

    // after reset nothing is enabled and the count cannot leave zero
    task automatic test_reset_state();
        send_tick(32'd0);
        send_tick(32'd1);
        send_tick(32'h0000_5555);
        send_tick(32'h0000_2aaa);
        send_tick(32'h0000_ffff);
    endtask

    task automatic test_slot_cases();
        int n;
        // always-firing slot, phase 2 of 3, offset equal to divisor never fires
        set_slot(0, 1, 0);
        set_slot(1, 3, 2);
        set_slot(2, 4, 4);
        next_conn = 16'hffff;
        apply_settings();
        for (n = 0; n < 6; n++)
            send_tick(32'h0001_0000 + n);
        // unconnected slot 1, disabled slot 2 with its mask bit set
        set_slot(0, 5, 4);
        set_slot(1, 7, 6);
        set_slot(2, 0, 16'hffff);
        next_conn = 16'hfffd;
        apply_settings();
        for (n = 0; n < 6; n++)
            send_tick(32'h0000_8000 >> n);
        // wrap limit drops below the current count
        set_slot(0, 2, 0);
        set_slot(1, 0, 0);
        set_slot(2, 0, 0);
        next_conn = 16'h0007;
        apply_settings();
        for (n = 0; n < 4; n++)
            send_tick(32'h0012_3456 + n);
    endtask

    task automatic test_random_settings();
        int phase;
        int n;
        int count;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick_settings();
            apply_settings();
            count = $urandom_range(20, 40);
            for (n = 0; n < count; n++)
                send_tick(draw_elapsed(31 - phase * 31 / RANDOM_PHASES));
        end
    endtask

    // back-to-back ticks with both sides always ready
    task automatic test_steady_stream();
        int n;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        pick_settings();
        apply_settings();
        for (n = 0; n < 200; n++)
            send_tick(draw_elapsed(0));
        wait_drained();
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // status side stalls long enough that the tick side backs up
    task automatic test_output_hold_off();
        int n;
        send_idle = 1'b0;
        pick_settings();
        apply_settings();
        hold_left = HOLD_CYCLES;
        for (n = 0; n < 12; n++)
            send_tick(draw_elapsed(0));
        wait_drained();
        send_idle = 1'b1;
    endtask

    task automatic test_extreme_settings();
        int s;
        int n;
        // largest divisors, offset zero: fires once per 65535 ticks
        for (s = 0; s < MASK_W; s++)
            set_slot(s, 16'hffff, 16'h0000);
        next_conn = 16'h0007;
        apply_settings();
        send_tick(32'h8000_0000);
        send_tick(32'hffff_ffff);
        for (n = 0; n < 18; n++)
            send_tick(draw_elapsed(0));
        // largest offsets never fire
        for (s = 0; s < MASK_W; s++)
            set_slot(s, 16'hffff, 16'hffff);
        next_conn = 16'hffff;
        apply_settings();
        for (n = 0; n < 20; n++)
            send_tick(draw_elapsed(0));
        // everything off again, wrap limit back to one
        for (s = 0; s < MASK_W; s++)
            set_slot(s, 16'h0000, 16'hffff);
        next_conn = 16'h0000;
        apply_settings();
        for (n = 0; n < 20; n++)
            send_tick(draw_elapsed(0));
    endtask

    // status sink: check each beat, then pick ready for the next edge
    initial
    begin : status_sink
        status.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && status.valid && status.ready)
                check_status();
            if (hold_left > 0)
            begin
                hold_left--;
                status.ready <= 1'b0;
            end
            else
            begin
                status.ready <= !(recv_idle && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((tick.valid && tick.ready) || (status.valid && status.ready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n           = 1'b0;
        tick.valid      = 1'b0;
        tick.elapsed_us = '0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        divider_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_slot_cases();
        test_random_settings();
        test_steady_stream();
        test_output_hold_off();
        test_extreme_settings();

        // let any stray beat show up before judging
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/rgtd_pkg.sv
rtl/core/rgtd_tick_if.sv
rtl/core/rgtd_status_if.sv
rtl/core/rgtd_cfg_regs.sv
rtl/core/rgtd_arith_unit.sv
rtl/core/rgtd_seq.sv
rtl/core/rate_group_tick_divider_core.sv
rtl/core/rgtd_checker.sv
sim/testbench.sv
